FILE: hdl/bwh_pkg.sv
// Package for the binned weighted histogram fill block.
// Holds sizes, bin edge tables, status codes, state and memory word types.
// Used by every other file of the block but the two channel interfaces; depends on nothing.
package bwh_pkg;

	localparam int CELL_DEPTH  = 1024;
	localparam int Z_BIN_COUNT = 5;
	localparam int AW          = $clog2(CELL_DEPTH);
	localparam int ZBW         = (Z_BIN_COUNT > 1) ? $clog2(Z_BIN_COUNT) : 1;
	localparam int PHI_BINS    = 5;
	localparam int PHI_STEP    = 4608;
	localparam int HW          = $clog2(Z_BIN_COUNT * PHI_BINS + 1);

	localparam logic [2:0] ADDR_PHI_MODE = 3'd0;
	localparam logic [2:0] ADDR_GRID_SEL = 3'd4;

	localparam logic [31:0] SQ_LIMIT = 32'd3037000499;
	localparam logic [62:0] MAX63    = {63{1'b1}};

	localparam logic [16:0] XB_EDGES0 [8] = '{17'd6554, 17'd7209, 17'd8520, 17'd10486,
		17'd13108, 17'd16384, 17'd23593, 17'd65536};
	localparam logic [16:0] TH_EDGES0 [4] = '{17'd1946, 17'd2151, 17'd2637, 17'd5888};
	localparam logic [16:0] XB_EDGES1 [6] = '{17'd6554, 17'd7209, 17'd9831, 17'd12452,
		17'd19006, 17'd65536};
	localparam logic [16:0] TH_EDGES1 [4] = '{17'd1946, 17'd2253, 17'd2816, 17'd5888};

	typedef enum logic [1:0] {
		ST_FILLED = 2'd0,
		ST_RANGE  = 2'd1,
		ST_GRID   = 2'd2,
		ST_READ   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_BIN,
		S_MUL,
		S_UPD
	} fsm_state_t;

	typedef struct packed {
		logic phi_mode;
		logic grid_select;
	} cfg_t;

	typedef struct packed {
		status_t         status;
		logic [AW-1:0]   cell_idx;
	} bin_res_t;

	typedef struct packed {
		logic [47:0] w;
		logic [55:0] w2;
		logic [62:0] w4;
		logic [31:0] n;
	} mem_word_t;

	// Lower z edge k, rounded up to the Q0.16 grid.
	function automatic logic [16:0] z_edge(input int k);
		return 17'(((30 + 8 * k) * 65536 + 99) / 100);
	endfunction

endpackage

FILE: hdl/bwh_in_if.sv
// Request channel of the histogram block: valid, ready and one input item.
// Depends on nothing.
interface bwh_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic        [15:0] z_frac;
	logic signed [15:0] phi_deg;
	logic        [15:0] xb_frac;
	logic        [15:0] theta_deg;
	logic        [15:0] pt2_val;
	logic         [9:0] read_index;

	modport source (output valid, req_type, z_frac, phi_deg, xb_frac, theta_deg, pt2_val,
		read_index, input ready);
	modport sink (input valid, req_type, z_frac, phi_deg, xb_frac, theta_deg, pt2_val,
		read_index, output ready);
endinterface

FILE: hdl/bwh_out_if.sv
// Result channel of the histogram block: valid, ready and one result item.
// Depends on nothing.
interface bwh_out_if;
	logic        valid;
	logic        ready;
	logic  [1:0] status;
	logic  [9:0] cell_index;
	logic [47:0] sum_weight;
	logic [55:0] sum_weight_sq;
	logic [62:0] sum_weight_fourth;
	logic [31:0] event_count;

	modport source (output valid, status, cell_index, sum_weight, sum_weight_sq,
		sum_weight_fourth, event_count, input ready);
	modport sink (input valid, status, cell_index, sum_weight, sum_weight_sq,
		sum_weight_fourth, event_count, output ready);
endinterface

FILE: hdl/bwh_cfg.sv
// APB register file with the phi mode and grid select registers.
// Depends on bwh_pkg.
module bwh_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic        [2:0] paddr,
	input  logic       [31:0] pwdata,
	output logic       [31:0] prdata,
	output logic              pready,
	output bwh_pkg::cfg_t     cfg
);
	bwh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				cfg_q.grid_select <= pwdata[0];
			end else begin
				cfg_q.phi_mode <= pwdata[0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {31'd0, cfg_q.grid_select} : {31'd0, cfg_q.phi_mode};
	assign cfg    = cfg_q;
endmodule

FILE: hdl/bwh_binner.sv
// Bin search for one fill item: z, phi, xB and theta bins and the cell number.
// Depends on bwh_pkg.
module bwh_binner (
	input  bwh_pkg::cfg_t     cfg,
	input  logic       [15:0] z_frac,
	input  logic       [15:0] phi_deg,
	input  logic       [15:0] xb_frac,
	input  logic       [15:0] theta_deg,
	output bwh_pkg::bin_res_t res
);
	logic [bwh_pkg::ZBW-1:0] iz;
	logic                    z_ok;
	logic              [2:0] iph;
	logic                    phi_ok;
	logic [bwh_pkg::HW-1:0]  hist;
	logic              [2:0] ix0, ix1, iy0, iy1, ix, iy;
	logic                    x0_ok, x1_ok, y0_ok, y1_ok, x_ok, y_ok;
	logic              [4:0] nx;
	logic             [15:0] cell_num;

	always_comb begin
		iz   = '0;
		z_ok = 1'b0;
		for (int k = 0; k < bwh_pkg::Z_BIN_COUNT; k++) begin
			if ({1'b0, z_frac} >= bwh_pkg::z_edge(k)
					&& {1'b0, z_frac} < bwh_pkg::z_edge(k + 1)) begin
				iz   = bwh_pkg::ZBW'(k);
				z_ok = 1'b1;
			end
		end
	end

	always_comb begin
		phi_ok = !phi_deg[15] && (32'(phi_deg) < bwh_pkg::PHI_STEP * bwh_pkg::PHI_BINS);
		iph    = '0;
		for (int k = 1; k < bwh_pkg::PHI_BINS; k++) begin
			if (32'(phi_deg[14:0]) >= bwh_pkg::PHI_STEP * k) begin
				iph = 3'(k);
			end
		end
	end

	always_comb begin
		ix0 = '0; ix1 = '0; iy0 = '0; iy1 = '0;
		x0_ok = 1'b0; x1_ok = 1'b0; y0_ok = 1'b0; y1_ok = 1'b0;
		for (int j = 0; j < 7; j++) begin
			if ({1'b0, xb_frac} >= bwh_pkg::XB_EDGES0[j]
					&& {1'b0, xb_frac} < bwh_pkg::XB_EDGES0[j+1]) begin
				ix0 = 3'(j); x0_ok = 1'b1;
			end
		end
		for (int j = 0; j < 5; j++) begin
			if ({1'b0, xb_frac} >= bwh_pkg::XB_EDGES1[j]
					&& {1'b0, xb_frac} < bwh_pkg::XB_EDGES1[j+1]) begin
				ix1 = 3'(j); x1_ok = 1'b1;
			end
		end
		for (int j = 0; j < 3; j++) begin
			if ({1'b0, theta_deg} >= bwh_pkg::TH_EDGES0[j]
					&& {1'b0, theta_deg} < bwh_pkg::TH_EDGES0[j+1]) begin
				iy0 = 3'(j); y0_ok = 1'b1;
			end
			if ({1'b0, theta_deg} >= bwh_pkg::TH_EDGES1[j]
					&& {1'b0, theta_deg} < bwh_pkg::TH_EDGES1[j+1]) begin
				iy1 = 3'(j); y1_ok = 1'b1;
			end
		end
	end

	always_comb begin
		ix   = cfg.grid_select ? ix1 : ix0;
		iy   = cfg.grid_select ? iy1 : iy0;
		x_ok = cfg.grid_select ? x1_ok : x0_ok;
		y_ok = cfg.grid_select ? y1_ok : y0_ok;
		nx   = cfg.grid_select ? 5'd5 : 5'd7;
		hist = cfg.phi_mode
			? bwh_pkg::HW'(iz) * bwh_pkg::HW'(bwh_pkg::PHI_BINS) + bwh_pkg::HW'(iph)
			: bwh_pkg::HW'(iz);
		cell_num = 16'(hist) * 16'(nx) * 16'd3 + 16'(iy) * 16'(nx) + 16'(ix);
		res.cell_idx = '0;
		if (!z_ok || (cfg.phi_mode && !phi_ok)) begin
			res.status = bwh_pkg::ST_RANGE;
		end else if (!x_ok || !y_ok || 32'(cell_num) >= bwh_pkg::CELL_DEPTH) begin
			res.status = bwh_pkg::ST_GRID;
		end else begin
			res.status   = bwh_pkg::ST_FILLED;
			res.cell_idx = bwh_pkg::AW'(cell_num);
		end
	end
endmodule

FILE: hdl/bwh_store.sv
// Accumulator memory: one write port and one registered read port.
// Depends on bwh_pkg.
module bwh_store (
	input  logic                   clk,
	input  logic                   we,
	input  logic [bwh_pkg::AW-1:0] waddr,
	input  bwh_pkg::mem_word_t     wdata,
	input  logic                   re,
	input  logic [bwh_pkg::AW-1:0] raddr,
	output bwh_pkg::mem_word_t     rdata
);
	bwh_pkg::mem_word_t mem [bwh_pkg::CELL_DEPTH];
	bwh_pkg::mem_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: hdl/binned_weighted_histogram_fill.sv
// Weighted histogram fill: a new item is taken only once the last one's result is
// registered through bin and square, fourth power and update; update waits for the receiver.
// Throughput is set by the read-modify-write of the single accumulator memory.
// After reset a clearing pass zeroes all CELL_DEPTH cells, one per cycle,
// and no item is taken until it ends. Only state, clear counter and valid flag reset.
module binned_weighted_histogram_fill (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic  [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bwh_in_if.sink      req,
	bwh_out_if.source   rsp
);
	bwh_pkg::cfg_t      cfg;
	bwh_pkg::fsm_state_t state_q, state_nx;
	bwh_pkg::bin_res_t  bres;
	bwh_pkg::mem_word_t rd_data, wr_data;

	logic [bwh_pkg::AW-1:0] clr_q;
	logic        type_q;
	logic [15:0] z_q, phi_q, xb_q, th_q, pt2_q;
	logic  [9:0] ridx_q;

	bwh_pkg::status_t       sts_s1;
	logic [bwh_pkg::AW-1:0] cell_s1;
	logic                   oob_s1;
	logic [31:0]            sq_s1;
	logic [62:0]            four_s2;

	logic        out_vld_q;
	logic  [1:0] sts_q;
	logic  [9:0] cidx_q;
	logic [47:0] w_q;
	logic [55:0] w2_q;
	logic [62:0] w4_q;
	logic [31:0] n_q;

	logic        accept, go, fill_ok, we, re;
	logic [bwh_pkg::AW-1:0] waddr, raddr;
	logic [48:0] w_sum;
	logic [56:0] w2_sum;
	logic [63:0] w4_sum;
	logic [32:0] n_sum;
	logic [63:0] sq_prod;

	bwh_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	bwh_binner u_binner (
		.cfg, .z_frac(z_q), .phi_deg(phi_q), .xb_frac(xb_q), .theta_deg(th_q), .res(bres)
	);

	bwh_store u_store (
		.clk, .we, .waddr, .wdata(wr_data), .re, .raddr, .rdata(rd_data)
	);

	assign accept = req.valid && req.ready;
	assign go     = !out_vld_q || rsp.ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bwh_pkg::S_CLEAR: if (32'(clr_q) == bwh_pkg::CELL_DEPTH - 1) state_nx = bwh_pkg::S_IDLE;
			bwh_pkg::S_IDLE:  if (accept) state_nx = bwh_pkg::S_BIN;
			bwh_pkg::S_BIN:   state_nx = bwh_pkg::S_MUL;
			bwh_pkg::S_MUL:   state_nx = bwh_pkg::S_UPD;
			bwh_pkg::S_UPD:   if (go) state_nx = bwh_pkg::S_IDLE;
			default:          state_nx = bwh_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		w_sum   = {1'b0, rd_data.w} + 49'(pt2_q);
		w2_sum  = {1'b0, rd_data.w2} + 57'(sq_s1);
		w4_sum  = {1'b0, rd_data.w4} + 64'(four_s2);
		n_sum   = {1'b0, rd_data.n} + 33'd1;
		wr_data.w  = w_sum[48] ? {48{1'b1}} : w_sum[47:0];
		wr_data.w2 = w2_sum[56] ? {56{1'b1}} : w2_sum[55:0];
		wr_data.w4 = w4_sum[63] ? bwh_pkg::MAX63 : w4_sum[62:0];
		wr_data.n  = n_sum[32] ? {32{1'b1}} : n_sum[31:0];
		fill_ok = !type_q && (sts_s1 == bwh_pkg::ST_FILLED);
		req.ready = (state_q == bwh_pkg::S_IDLE);
		re      = (state_q == bwh_pkg::S_BIN);
		raddr   = type_q ? bwh_pkg::AW'(ridx_q) : bres.cell_idx;
		we      = 1'b0;
		waddr   = cell_s1;
		if (state_q == bwh_pkg::S_CLEAR) begin
			we      = 1'b1;
			waddr   = clr_q;
			wr_data = '0;
		end else if (state_q == bwh_pkg::S_UPD && go && fill_ok) begin
			we = 1'b1;
		end
	end

	assign sq_prod = 64'(sq_s1) * 64'(sq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bwh_pkg::S_CLEAR;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == bwh_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == bwh_pkg::S_UPD && go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			z_q    <= req.z_frac;
			phi_q  <= req.phi_deg;
			xb_q   <= req.xb_frac;
			th_q   <= req.theta_deg;
			pt2_q  <= req.pt2_val;
			ridx_q <= req.read_index;
		end
		if (state_q == bwh_pkg::S_BIN) begin
			sts_s1  <= type_q ? bwh_pkg::ST_READ : bres.status;
			cell_s1 <= bres.cell_idx;
			oob_s1  <= (32'(ridx_q) >= bwh_pkg::CELL_DEPTH);
			sq_s1   <= pt2_q * pt2_q;
		end
		if (state_q == bwh_pkg::S_MUL) begin
			four_s2 <= (sq_s1 > bwh_pkg::SQ_LIMIT) ? bwh_pkg::MAX63 : sq_prod[62:0];
		end
		if (state_q == bwh_pkg::S_UPD && go) begin
			sts_q <= sts_s1;
			if (type_q) begin
				cidx_q <= ridx_q;
				w_q    <= oob_s1 ? '0 : rd_data.w;
				w2_q   <= oob_s1 ? '0 : rd_data.w2;
				w4_q   <= oob_s1 ? '0 : rd_data.w4;
				n_q    <= oob_s1 ? '0 : rd_data.n;
			end else if (fill_ok) begin
				cidx_q <= 10'(cell_s1);
				w_q    <= wr_data.w;
				w2_q   <= wr_data.w2;
				w4_q   <= wr_data.w4;
				n_q    <= wr_data.n;
			end else begin
				cidx_q <= '0;
				w_q    <= '0;
				w2_q   <= '0;
				w4_q   <= '0;
				n_q    <= '0;
			end
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.status            = sts_q;
	assign rsp.cell_index        = cidx_q;
	assign rsp.sum_weight        = w_q;
	assign rsp.sum_weight_sq     = w2_q;
	assign rsp.sum_weight_fourth = w4_q;
	assign rsp.event_count       = n_q;
endmodule

FILE: tb/sv/binned_weighted_histogram_fill_chk.sv
// Result checker for the binned weighted histogram fill block.
// Watches the request and result channels and the register writes, keeps its own
// histogram store, and compares every result. Depends on bwh_pkg and both channel interfaces.
module binned_weighted_histogram_fill_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic  [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	bwh_in_if           req,
	bwh_out_if          rsp,
	output int          errors,
	output int          pending,
	output int          n_fill,
	output int          n_read,
	output int          n_range,
	output int          n_grid
);

	localparam logic [47:0] MAX48 = {48{1'b1}};
	localparam logic [55:0] MAX56 = {56{1'b1}};
	localparam logic [31:0] MAX32 = {32{1'b1}};

	typedef struct packed {
		bwh_pkg::status_t status;
		logic [9:0]  cell_idx;
		logic [47:0] w;
		logic [55:0] w2;
		logic [62:0] w4;
		logic [31:0] n;
	} cell_result_t;

	bwh_pkg::mem_word_t hist_store [bwh_pkg::CELL_DEPTH];
	cell_result_t expected_cells [$];
	logic         phi_on;
	logic         grid_alt;

	function automatic int bin_of(input int v, input int edges [], input int cnt);
		for (int j = 0; j + 1 < cnt; j++) begin
			if (v >= edges[j] && v < edges[j + 1]) return j;
		end
		return -1;
	endfunction

	task automatic queue_result(input cell_result_t r);
		expected_cells.insert(expected_cells.size(), r);
	endtask

	task automatic fill_or_read();
		cell_result_t r;
		int iz, ix, iy, nx, hist, cell_num, lo, hi;
		int xe [], te [];
		logic [63:0] sq, four;
		logic [64:0] t;
		r = '0;
		iz = -1;
		if (req.req_type) begin
			r.status = bwh_pkg::ST_READ;
			r.cell_idx = req.read_index;
			if (int'(req.read_index) < bwh_pkg::CELL_DEPTH) begin
				r.w = hist_store[req.read_index].w;
				r.w2 = hist_store[req.read_index].w2;
				r.w4 = hist_store[req.read_index].w4;
				r.n = hist_store[req.read_index].n;
			end
			n_read++;
			queue_result(r);
			return;
		end
		for (int k = 0; k < bwh_pkg::Z_BIN_COUNT; k++) begin
			lo = ((30 + 8 * k) * 65536 + 99) / 100;
			hi = ((30 + 8 * (k + 1)) * 65536 + 99) / 100;
			if (iz < 0 && int'(req.z_frac) >= lo && int'(req.z_frac) < hi) iz = k;
		end
		if (iz < 0 || (phi_on && (req.phi_deg < 0
				|| int'(req.phi_deg) >= bwh_pkg::PHI_STEP * bwh_pkg::PHI_BINS))) begin
			r.status = bwh_pkg::ST_RANGE;
			n_range++;
			queue_result(r);
			return;
		end
		hist = phi_on ? iz * bwh_pkg::PHI_BINS + int'(req.phi_deg) / bwh_pkg::PHI_STEP : iz;
		if (grid_alt) begin
			xe = {6554, 7209, 9831, 12452, 19006, 65536};
			te = {1946, 2253, 2816, 5888};
			nx = 5;
		end else begin
			xe = {6554, 7209, 8520, 10486, 13108, 16384, 23593, 65536};
			te = {1946, 2151, 2637, 5888};
			nx = 7;
		end
		ix = bin_of(int'(req.xb_frac), xe, nx + 1);
		iy = bin_of(int'(req.theta_deg), te, 4);
		cell_num = hist * nx * 3 + iy * nx + ix;
		if (ix < 0 || iy < 0 || cell_num >= bwh_pkg::CELL_DEPTH) begin
			r.status = bwh_pkg::ST_GRID;
			n_grid++;
			queue_result(r);
			return;
		end
		sq = 64'(req.pt2_val) * 64'(req.pt2_val);
		four = (sq > 64'(bwh_pkg::SQ_LIMIT)) ? 64'(bwh_pkg::MAX63) : sq * sq;
		if (four > 64'(bwh_pkg::MAX63)) four = 64'(bwh_pkg::MAX63);
		t = 65'(hist_store[cell_num].w) + 65'(req.pt2_val);
		hist_store[cell_num].w = (t > 65'(MAX48)) ? MAX48 : t[47:0];
		t = 65'(hist_store[cell_num].w2) + 65'(sq);
		hist_store[cell_num].w2 = (t > 65'(MAX56)) ? MAX56 : t[55:0];
		t = 65'(hist_store[cell_num].w4) + 65'(four);
		hist_store[cell_num].w4 = (t > 65'(bwh_pkg::MAX63)) ? bwh_pkg::MAX63 : t[62:0];
		if (hist_store[cell_num].n != MAX32) hist_store[cell_num].n = hist_store[cell_num].n + 1;
		r.status = bwh_pkg::ST_FILLED;
		r.cell_idx = 10'(cell_num);
		r.w = hist_store[cell_num].w;
		r.w2 = hist_store[cell_num].w2;
		r.w4 = hist_store[cell_num].w4;
		r.n = hist_store[cell_num].n;
		n_fill++;
		queue_result(r);
	endtask

	task automatic compare_result();
		cell_result_t e, a;
		a.status = bwh_pkg::status_t'(rsp.status);
		a.cell_idx = rsp.cell_index;
		a.w = rsp.sum_weight;
		a.w2 = rsp.sum_weight_sq;
		a.w4 = rsp.sum_weight_fourth;
		a.n = rsp.event_count;
		if (expected_cells.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result item: %p", a);
			return;
		end
		e = expected_cells.pop_front();
		if (a.status !== e.status || a.cell_idx !== e.cell_idx || a.w !== e.w || a.w2 !== e.w2
				|| a.w4 !== e.w4 || a.n !== e.n) begin
			errors++;
			if (errors <= 10) $display("result mismatch: expected %p, actual %p", e, a);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bwh_pkg::CELL_DEPTH; i++) hist_store[i] = '0;
			expected_cells.delete();
			phi_on = 1'b0;
			grid_alt = 1'b0;
			errors = 0;
			n_fill = 0;
			n_read = 0;
			n_range = 0;
			n_grid = 0;
		end else begin
			if (rsp.valid && rsp.ready) compare_result();
			if (req.valid && req.ready) fill_or_read();
			if (psel && penable && pwrite && pready) begin
				if (paddr == bwh_pkg::ADDR_PHI_MODE) phi_on = pwdata[0];
				if (paddr == bwh_pkg::ADDR_GRID_SEL) grid_alt = pwdata[0];
			end
		end
		pending = expected_cells.size();
	end

endmodule

FILE: tb/sv/binned_weighted_histogram_fill_tb.sv
// Top of the histogram fill testbench: clock, reset, register writes and item stimulus.
// Instantiates the block and its checker; depends on bwh_pkg and the channel interfaces.
module binned_weighted_histogram_fill_tb;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic  [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors, pending, n_fill, n_read, n_range, n_grid;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          stim_done = 1'b0;

	bwh_in_if  req ();
	bwh_out_if rsp ();

	binned_weighted_histogram_fill DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .req(req), .rsp(rsp)
	);

	binned_weighted_histogram_fill_chk checker_i (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending), .n_fill(n_fill), .n_read(n_read),
		.n_range(n_range), .n_grid(n_grid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.z_frac = '0;
		req.phi_deg = '0;
		req.xb_frac = '0;
		req.theta_deg = '0;
		req.pt2_val = '0;
		req.read_index = '0;
		rsp.ready = 1'b0;
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The valid line stays high after acceptance; a gap before the next item, or drain(), lowers it.
	task automatic send_item(input logic rt, input logic [15:0] z, input logic [15:0] phi,
			input logic [15:0] xb, input logic [15:0] th, input logic [15:0] pt2,
			input logic [9:0] ridx, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.z_frac <= z;
		req.phi_deg <= phi;
		req.xb_frac <= xb;
		req.theta_deg <= th;
		req.pt2_val <= pt2;
		req.read_index <= ridx;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_fill(input logic [15:0] z, input logic [15:0] phi, input logic [15:0] xb,
			input logic [15:0] th, input logic [15:0] pt2);
		send_item(1'b0, z, phi, xb, th, pt2, 10'($urandom), 1'b1);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly in-range fills, some at low xB or full pt2; the rest are reads and random fills.
	task automatic random_items(input int count, input bit gaps);
		int pick;
		logic [15:0] z, phi, xb, th;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			z = 16'($urandom_range(19661, 45874));
			phi = 16'($urandom_range(0, 23039));
			xb = 16'($urandom_range(6554, 65535));
			th = 16'($urandom_range(1946, 5887));
			if (pick < 8) begin
				send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom), gaps);
			end else if (pick < 14) begin
				send_fill(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			end else begin
				if (pick < 20) xb = 16'($urandom_range(6554, 8000));
				send_item(1'b0, z, phi, xb, th,
					(pick > 92) ? 16'hFFFF : 16'($urandom), 10'($urandom), gaps);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Extremes of every field and each out-of-range class.
		send_fill(16'd19661, 16'd0, 16'd6554, 16'd1946, 16'hFFFF);
		send_fill(16'd19661, 16'd0, 16'd6554, 16'd1946, 16'hFFFF);
		send_fill(16'd19660, 16'd0, 16'd7000, 16'd2000, 16'd1);
		send_fill(16'd45875, 16'd0, 16'd7000, 16'd2000, 16'd1);
		send_fill(16'd45874, 16'h8000, 16'd65535, 16'd5887, 16'd0);
		send_fill(16'hFFFF, 16'h7FFF, 16'd7000, 16'd2000, 16'd5);
		send_fill(16'd0, 16'hFFFF, 16'd7000, 16'd2000, 16'd5);
		send_fill(16'd30000, 16'd0, 16'd6553, 16'd2000, 16'd5);
		send_fill(16'd30000, 16'd0, 16'd7000, 16'd1945, 16'd5);
		send_fill(16'd30000, 16'd0, 16'd7000, 16'd5888, 16'd5);
		send_fill(16'd30000, 16'd0, 16'd0, 16'hFFFF, 16'd5);
		send_fill(16'd30000, 16'd0, 16'd20000, 16'd2500, 16'd3037);
		send_fill(16'd30000, 16'd0, 16'd20000, 16'd2500, 16'd55109);
		send_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0, 1'b1);
		send_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'h3FF, 1'b1);
		drain();
		reg_write(bwh_pkg::ADDR_PHI_MODE, 32'hFFFF_FFFF);
		reg_write(bwh_pkg::ADDR_GRID_SEL, 32'h0000_0001);
		send_fill(16'd45874, 16'd23039, 16'd65535, 16'd5887, 16'hFFFF);
		send_fill(16'd30000, 16'd23040, 16'd7000, 16'd2000, 16'd5);
		send_fill(16'd30000, 16'hFFFF, 16'd7000, 16'd2000, 16'd5);
		send_fill(16'd30000, 16'd4608, 16'd19006, 16'd2816, 16'd77);
		send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd524, 1'b1);
		// Long receiver hold-off while items keep coming.
		hold_off = 1'b1;
		random_items(60, 1'b0);
		drain();
		// Random items with gaps under several settings of phi mode and grid select.
		random_items(400, 1'b1);
		drain();
		reg_write(bwh_pkg::ADDR_PHI_MODE, 32'h0);
		random_items(400, 1'b1);
		drain();
		reg_write(bwh_pkg::ADDR_GRID_SEL, 32'h0);
		reg_write(bwh_pkg::ADDR_PHI_MODE, 32'h1);
		random_items(400, 1'b1);
		drain();
		reg_write(bwh_pkg::ADDR_GRID_SEL, 32'h1);
		reg_write(bwh_pkg::ADDR_PHI_MODE, 32'h0);
		random_items(460, 1'b1);
		for (int i = 0; i < 1024; i += 97)
			send_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'(i), 1'b0);
		req.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (hold_off) begin
				stall = 300;
				hold_off = 1'b0;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
			rsp.ready <= (stall == 0);
			if (stall != 0) begin
				repeat (stall) @(posedge clk);
				rsp.ready <= 1'b1;
			end
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d fills, %0d reads, %0d out-of-range and %0d off-grid events",
			n_fill, n_read, n_range, n_grid);
		$display("over both grids with phi binning on and off");
		if (errors == 0 && pending == 0) $display("binned_weighted_histogram_fill_tb passed");
		else $display("binned_weighted_histogram_fill_tb failed");
		$finish;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("binned_weighted_histogram_fill_tb failed");
		$finish;
	end

endmodule
